### hw/rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STS_W  = 2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [OP_W-1:0]   t_op;
    typedef logic [STS_W-1:0]  t_sts;

    localparam t_op OP_PUSH_HEAD = 3'd0;
    localparam t_op OP_PUSH_TAIL = 3'd1;
    localparam t_op OP_POP_HEAD  = 3'd2;
    localparam t_op OP_POP_TAIL  = 3'd3;
    localparam t_op OP_COUNT     = 3'd4;
    localparam t_op OP_DELETE    = 3'd5;

    localparam t_sts STS_DONE  = 2'd0;
    localparam t_sts STS_FULL  = 2'd1;
    localparam t_sts STS_EMPTY = 2'd2;

    // Store position of the entry at a given offset from the head.
    function automatic t_idx slot_of(input t_idx front, input t_cnt off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(front) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Store position just ahead of the head.
    function automatic t_idx prev_of(input t_idx front);
        t_idx res;
        if (front == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = front - 1'b1;
        end
        return res;
    endfunction

endpackage

### hw/rtl/bdq_if.sv
`timescale 1ns / 1ps

interface bdq_req_if;
    logic            valid;
    logic            ready;
    bdq_pkg::t_op    op;
    bdq_pkg::t_data  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic            valid;
    logic            ready;
    bdq_pkg::t_data  head_value;
    bdq_pkg::t_data  tail_value;
    bdq_pkg::t_cnt   count;
    bdq_pkg::t_cnt   matches_res;
    bdq_pkg::t_sts   status;

    modport source (output valid, output head_value, output tail_value, output count,
                    output matches_res, output status, input ready);
    modport sink   (input valid, input head_value, input tail_value, input count,
                    input matches_res, input status, output ready);
endinterface

### hw/rtl/bounded_deque_with_match_delete.sv
`timescale 1ns / 1ps

// Bounded deque of up to DEPTH 32-bit values held in a circular single-port-read,
// single-port-write memory. Each request (push or pop at either end, count
// matches, delete matches) gives exactly one response carrying the head, tail,
// length, match count and status. Requests are worked one at a time: push, pop
// and undefined ops go from execute straight to the head/tail readback; count
// and delete first walk the stored entries through the memory read port, one
// per cycle. The head and tail are read back from memory after every request
// that leaves the list non-empty, and are given as zero when it is empty.
// A new request is taken while the previous response still waits on the
// output register.

module bounded_deque_with_match_delete (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_req_if.sink   i_req,
    bdq_rsp_if.source o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RDH  = 3'd3;
    localparam logic [2:0] S_RDT  = 3'd4;
    localparam logic [2:0] S_CAPT = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    bdq_pkg::t_data r_mem [bdq_pkg::DEPTH];
    bdq_pkg::t_data r_rd_data;

    logic [2:0]     r_state, n_state;
    bdq_pkg::t_op   r_op, n_op;
    bdq_pkg::t_data r_val, n_val;
    bdq_pkg::t_idx  r_front, n_front;
    bdq_pkg::t_cnt  r_count, n_count;
    bdq_pkg::t_cnt  r_rd_idx, n_rd_idx;
    logic           r_chk, n_chk;
    bdq_pkg::t_cnt  r_kept, n_kept;
    bdq_pkg::t_cnt  r_match, n_match;
    bdq_pkg::t_sts  r_sts, n_sts;
    bdq_pkg::t_data r_head, n_head;
    bdq_pkg::t_data r_tail, n_tail;

    logic           r_out_valid, n_out_valid;
    bdq_pkg::t_data r_out_head, n_out_head;
    bdq_pkg::t_data r_out_tail, n_out_tail;
    bdq_pkg::t_cnt  r_out_count, n_out_count;
    bdq_pkg::t_cnt  r_out_match, n_out_match;
    bdq_pkg::t_sts  r_out_sts, n_out_sts;

    logic           mem_we;
    bdq_pkg::t_idx  mem_wa;
    bdq_pkg::t_data mem_wd;
    bdq_pkg::t_idx  rd_addr;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.head_value  = r_out_head;
    assign o_rsp.tail_value  = r_out_tail;
    assign o_rsp.count       = r_out_count;
    assign o_rsp.matches_res = r_out_match;
    assign o_rsp.status      = r_out_sts;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_front     = r_front;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_chk       = r_chk;
        n_kept      = r_kept;
        n_match     = r_match;
        n_sts       = r_sts;
        n_head      = r_head;
        n_tail      = r_tail;
        n_out_valid = r_out_valid;
        n_out_head  = r_out_head;
        n_out_tail  = r_out_tail;
        n_out_count = r_out_count;
        n_out_match = r_out_match;
        n_out_sts   = r_out_sts;
        mem_we      = 1'b0;
        mem_wa      = r_front;
        mem_wd      = r_val;
        rd_addr     = r_front;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.op;
                    n_val   = i_req.value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_match  = '0;
                n_sts    = bdq_pkg::STS_DONE;
                n_rd_idx = '0;
                n_kept   = '0;
                n_chk    = 1'b0;
                n_state  = S_RDH;
                unique case (r_op)
                    bdq_pkg::OP_PUSH_HEAD: begin
                        if (r_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)) begin
                            n_sts = bdq_pkg::STS_FULL;
                        end else begin
                            n_front = bdq_pkg::prev_of(r_front);
                            mem_we  = 1'b1;
                            mem_wa  = bdq_pkg::prev_of(r_front);
                            n_count = r_count + 1'b1;
                        end
                    end
                    bdq_pkg::OP_PUSH_TAIL: begin
                        if (r_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)) begin
                            n_sts = bdq_pkg::STS_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            mem_wa  = bdq_pkg::slot_of(r_front, r_count);
                            n_count = r_count + 1'b1;
                        end
                    end
                    bdq_pkg::OP_POP_HEAD: begin
                        if (r_count == '0) begin
                            n_sts = bdq_pkg::STS_EMPTY;
                        end else begin
                            n_front = bdq_pkg::slot_of(r_front, bdq_pkg::CNT_W'(1));
                            n_count = r_count - 1'b1;
                        end
                    end
                    bdq_pkg::OP_POP_TAIL: begin
                        if (r_count == '0) begin
                            n_sts = bdq_pkg::STS_EMPTY;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    bdq_pkg::OP_COUNT, bdq_pkg::OP_DELETE: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // issue one read per cycle, check the entry read the cycle before
                n_chk = 1'b0;
                if (r_rd_idx != r_count) begin
                    rd_addr  = bdq_pkg::slot_of(r_front, r_rd_idx);
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_chk    = 1'b1;
                end
                if (r_chk) begin
                    if (r_rd_data == r_val) begin
                        n_match = r_match + 1'b1;
                    end else if (r_op == bdq_pkg::OP_DELETE) begin
                        mem_we = 1'b1;
                        mem_wa = bdq_pkg::slot_of(r_front, r_kept);
                        mem_wd = r_rd_data;
                        n_kept = r_kept + 1'b1;
                    end
                end
                if ((r_rd_idx == r_count) && !r_chk) begin
                    if (r_op == bdq_pkg::OP_DELETE) begin
                        n_count = r_kept;
                    end
                    n_state = S_RDH;
                end
            end
            S_RDH: begin
                if (r_count == '0) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_state = S_FIN;
                end else begin
                    rd_addr = r_front;
                    n_state = S_RDT;
                end
            end
            S_RDT: begin
                rd_addr = bdq_pkg::slot_of(r_front, r_count - 1'b1);
                n_head  = r_rd_data;
                n_state = S_CAPT;
            end
            S_CAPT: begin
                n_tail  = r_rd_data;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_head  = r_head;
                    n_out_tail  = r_tail;
                    n_out_count = r_count;
                    n_out_match = r_match;
                    n_out_sts   = r_sts;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_val       <= n_val;
        r_rd_idx    <= n_rd_idx;
        r_kept      <= n_kept;
        r_match     <= n_match;
        r_sts       <= n_sts;
        r_head      <= n_head;
        r_tail      <= n_tail;
        r_out_head  <= n_out_head;
        r_out_tail  <= n_out_tail;
        r_out_count <= n_out_count;
        r_out_match <= n_out_match;
        r_out_sts   <= n_out_sts;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
        else $error("entry count above depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |->
            ((bdq_pkg::CNT_W+1)'(r_kept) + (bdq_pkg::CNT_W+1)'(r_match)
             <= (bdq_pkg::CNT_W+1)'(r_rd_idx)))
        else $error("scan checked more entries than it read");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_EXEC) || (r_state == S_SCAN)))
        else $error("memory write outside execute or scan");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_sts == bdq_pkg::STS_FULL)) |->
            (r_out_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)))
        else $error("full refusal with room left");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_sts == bdq_pkg::STS_EMPTY)) |-> (r_out_count == '0))
        else $error("empty refusal with entries held");

endmodule
